// ===== design/pcms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcms_pkg
// Shared types and constants of the projector coordinate map sampler.
// ----------------------------------------------------------------------------
package pcms_pkg;

  localparam int COORD_W    = 20;
  localparam int SCALE_W    = 24;
  localparam int BOUND_W    = 13;
  localparam int PHASE_W    = 32;
  localparam int PROD_W     = 55;
  localparam int PROD_SHIFT = 24;
  localparam int POINT_W    = 22;
  localparam int PIX_W      = 9;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int WORD_W     = 2 * COORD_W + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [BOUND_W-1:0] BOUND_MAX = 13'd4096;

  localparam logic [SCALE_W-1:0] U_SCALE_RST = 24'd65536;
  localparam logic [SCALE_W-1:0] V_SCALE_RST = 24'd65536;
  localparam logic [BOUND_W-1:0] PROJ_W_RST  = 13'd1024;
  localparam logic [BOUND_W-1:0] PROJ_H_RST  = 13'd768;

  // Request field offsets in in_tdata
  localparam int PX_LSB   = 0;
  localparam int PY_LSB   = 9;
  localparam int PU_LSB   = 18;
  localparam int PV_LSB   = 50;
  localparam int PVLD_BIT = 82;
  localparam int QX_LSB   = 83;
  localparam int QY_LSB   = 105;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_U_SCALE = 2'd0,
    REG_V_SCALE = 2'd1,
    REG_PROJ_W  = 2'd2,
    REG_PROJ_H  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_TAIL1,
    BK_TAIL2,
    BK_DONE
  } bk_state_t;

  // act: store lies inside the image / query neighbourhood lies inside the image
  typedef struct packed {
    logic act;
    logic ok;
    op_t  kind;
  } cmd_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } coord_pair_t;

endpackage

// ===== design/pcms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pcms_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcms_queue
// Short FIFO between the request front end and the map back end.
// ----------------------------------------------------------------------------
module pcms_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue written while full");
`endif

endmodule

// ===== design/pcms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcms_front
// Request front end: configuration registers, request capture, phase scaling,
// bound checks and neighbourhood set-up, then hand-off to the queue.
// ----------------------------------------------------------------------------
module pcms_front
  import pcms_pkg::*;
#(
  parameter int IMG_W     = 512,
  parameter int IMG_H     = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,
  input  logic [IN_DATA_W-1:0]                in_tdata,
  input  logic                                clr_done,
  input  logic                                q_full,
  output logic                                q_push,
  output cmd_ctl_t                            q_ctl,
  output coord_pair_t                         q_coord,
  output logic [$clog2(IMG_W*IMG_H)-1:0]      q_addr,
  output logic [FRAC_BITS-1:0]                q_dx,
  output logic [FRAC_BITS-1:0]                q_dy
);

  localparam int ADDR_W = $clog2(IMG_W * IMG_H);
  localparam int QI_W   = POINT_W - 1 - FRAC_BITS;

  logic [SCALE_W-1:0] u_scale_r, v_scale_r;
  logic [BOUND_W-1:0] proj_w_r, proj_h_r;

  logic               a_vld_r, a_vld_nxt;
  op_t                a_op_r;
  logic [PIX_W-1:0]   a_px_r, a_py_r;
  logic [PHASE_W-1:0] a_pu_r, a_pv_r;
  logic               a_pvld_r;
  logic [POINT_W-1:0] a_qx_r, a_qy_r;

  logic               b_vld_r, b_vld_nxt;
  op_t                b_op_r;
  logic               b_act_r;
  logic               b_pvld_r;
  logic [ADDR_W-1:0]  b_addr_r;
  logic [PROD_W-1:0]  b_prod_u_r, b_prod_v_r;
  logic               b_neg_u_r, b_neg_v_r;
  logic [FRAC_BITS-1:0] b_dx_r, b_dy_r;

  logic               in_acc, a_go, b_go;
  logic [PHASE_W-2:0] pu_mag, pv_mag;
  logic               st_in_img, qr_in_img;
  logic [ADDR_W-1:0]  st_addr, qr_addr;
  logic [QI_W-1:0]    x0, y0;
  logic [BOUND_W-1:0] bu, bv;
  logic               gu, gv, st_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_scale_r <= U_SCALE_RST;
      v_scale_r <= V_SCALE_RST;
      proj_w_r  <= PROJ_W_RST;
      proj_h_r  <= PROJ_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_U_SCALE: u_scale_r <= cfg_wdata;
        REG_V_SCALE: v_scale_r <= cfg_wdata;
        REG_PROJ_W:  proj_w_r  <= cfg_wdata[BOUND_W-1:0];
        REG_PROJ_H:  proj_h_r  <= cfg_wdata[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  assign b_go      = !b_vld_r || !q_full;
  assign a_go      = a_vld_r && b_go;
  assign in_tready = clr_done && (!a_vld_r || b_go);
  assign in_acc    = in_tvalid && in_tready;
  assign q_push    = b_vld_r && !q_full;

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (in_acc) begin
      a_vld_nxt = 1'b1;
    end else if (b_go) begin
      a_vld_nxt = 1'b0;
    end
    b_vld_nxt = b_go ? a_vld_r : b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  // Stage A to B: scale phases, check image bounds, form base address
  assign pu_mag    = a_pu_r[PHASE_W-1] ? '0 : a_pu_r[PHASE_W-2:0];
  assign pv_mag    = a_pv_r[PHASE_W-1] ? '0 : a_pv_r[PHASE_W-2:0];
  assign st_in_img = (32'(a_px_r) < 32'(IMG_W)) && (32'(a_py_r) < 32'(IMG_H));
  assign st_addr   = ADDR_W'(32'(a_py_r) * 32'(IMG_W) + 32'(a_px_r));
  assign x0        = a_qx_r[POINT_W-2:FRAC_BITS];
  assign y0        = a_qy_r[POINT_W-2:FRAC_BITS];
  assign qr_in_img = !a_qx_r[POINT_W-1] && !a_qy_r[POINT_W-1] &&
                     (32'(x0) < 32'(IMG_W - 1)) && (32'(y0) < 32'(IMG_H - 1));
  assign qr_addr   = ADDR_W'(32'(y0) * 32'(IMG_W) + 32'(x0));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r   <= op_t'(in_tuser);
      a_px_r   <= in_tdata[PX_LSB +: PIX_W];
      a_py_r   <= in_tdata[PY_LSB +: PIX_W];
      a_pu_r   <= in_tdata[PU_LSB +: PHASE_W];
      a_pv_r   <= in_tdata[PV_LSB +: PHASE_W];
      a_pvld_r <= in_tdata[PVLD_BIT];
      a_qx_r   <= in_tdata[QX_LSB +: POINT_W];
      a_qy_r   <= in_tdata[QY_LSB +: POINT_W];
    end
    if (a_go) begin
      b_op_r     <= a_op_r;
      b_act_r    <= (a_op_r == OP_QUERY) ? qr_in_img : st_in_img;
      b_addr_r   <= (a_op_r == OP_QUERY) ? qr_addr : st_addr;
      b_pvld_r   <= a_pvld_r;
      b_prod_u_r <= PROD_W'(pu_mag) * PROD_W'(u_scale_r);
      b_prod_v_r <= PROD_W'(pv_mag) * PROD_W'(v_scale_r);
      b_neg_u_r  <= a_pu_r[PHASE_W-1];
      b_neg_v_r  <= a_pv_r[PHASE_W-1];
      b_dx_r     <= a_qx_r[FRAC_BITS-1:0];
      b_dy_r     <= a_qy_r[FRAC_BITS-1:0];
    end
  end

  // Stage B: projector bound test on the exact product
  assign bu    = (proj_w_r > BOUND_MAX) ? BOUND_MAX : proj_w_r;
  assign bv    = (proj_h_r > BOUND_MAX) ? BOUND_MAX : proj_h_r;
  assign gu    = (!b_neg_u_r || (u_scale_r == '0)) &&
                 (b_prod_u_r < PROD_W'({bu, 32'b0}));
  assign gv    = (!b_neg_v_r || (v_scale_r == '0)) &&
                 (b_prod_v_r < PROD_W'({bv, 32'b0}));
  assign st_ok = b_act_r && b_pvld_r && gu && gv;

  always_comb begin
    q_ctl.kind = b_op_r;
    q_ctl.act  = b_act_r;
    q_ctl.ok   = (b_op_r == OP_STORE) && st_ok;
    q_coord.u  = q_ctl.ok ? b_prod_u_r[PROD_SHIFT +: COORD_W] : '0;
    q_coord.v  = q_ctl.ok ? b_prod_v_r[PROD_SHIFT +: COORD_W] : '0;
  end

  assign q_addr = b_addr_r;
  assign q_dx   = b_dx_r;
  assign q_dy   = b_dy_r;

endmodule

// ===== design/pcms_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcms_back
// Map back end: clearing pass, map writes, 2x2 neighbourhood reads,
// bilinear multiply-accumulate and the reply register.
// ----------------------------------------------------------------------------
module pcms_back
  import pcms_pkg::*;
#(
  parameter int IMG_W     = 512,
  parameter int IMG_H     = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  cmd_ctl_t                        q_ctl,
  input  coord_pair_t                     q_coord,
  input  logic [$clog2(IMG_W*IMG_H)-1:0]  q_addr,
  input  logic [FRAC_BITS-1:0]            q_dx,
  input  logic [FRAC_BITS-1:0]            q_dy,
  output logic                            q_pop,
  output logic                            clr_done,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tuser,  // reply_kind
  output logic [OUT_DATA_W-1:0]           out_tdata   // ok, proj_u, proj_v
);

  localparam int MAP_DEPTH = IMG_W * IMG_H;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int WT_W      = 2 * FRAC_BITS + 1;
  localparam int ACC_W     = 2 * FRAC_BITS + COORD_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  bk_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  logic [ADDR_W-1:0]    base_r;
  logic [FRAC_BITS-1:0] dx_r, dy_r;
  logic                 start_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic                 rd_vld_r, prod_vld_r;
  logic [WT_W-1:0]      wt_r, wt_nxt;
  logic [FRAC_BITS:0]   wx, wy;
  logic [ACC_W-1:0]     prod_u_r, prod_v_r;
  logic                 prod_ok_r;
  logic [ACC_W-1:0]     acc_u_r, acc_v_r;
  logic                 allv_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  op_t                out_kind_r, out_kind_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [COORD_W-1:0] out_u_r, out_u_nxt, out_v_r, out_v_nxt;
  logic               out_free;

  pcms_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;
  assign clr_done = (state_r != BK_CLEAR);

  assign wx     = cnt_r[0] ? {1'b0, dx_r} : ONE - {1'b0, dx_r};
  assign wy     = cnt_r[1] ? {1'b0, dy_r} : ONE - {1'b0, dy_r};
  assign wt_nxt = WT_W'(wx) * WT_W'(wy);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    start_q      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = q_addr;
    ram_wdata    = {q_ctl.ok, q_coord.u, q_coord.v};
    ram_raddr    = base_r + (cnt_r[1] ? ADDR_W'(IMG_W) : '0) + ADDR_W'(cnt_r[0]);
    out_load     = 1'b0;
    out_kind_nxt = q_ctl.kind;
    out_ok_nxt   = q_ctl.ok;
    out_u_nxt    = q_coord.u;
    out_v_nxt    = q_coord.v;
    unique case (state_r)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_ctl.kind == OP_QUERY && q_ctl.act) begin
            start_q   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = BK_READ;
          end else begin
            ram_we   = (q_ctl.kind == OP_STORE) && q_ctl.act;
            out_load = 1'b1;
          end
        end
      end
      BK_READ: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = BK_TAIL1;
        end
      end
      BK_TAIL1: state_nxt = BK_TAIL2;
      BK_TAIL2: state_nxt = BK_DONE;
      BK_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = OP_QUERY;
          out_ok_nxt   = allv_r;
          out_u_nxt    = allv_r ? acc_u_r[2*FRAC_BITS +: COORD_W] : '0;
          out_v_nxt    = allv_r ? acc_v_r[2*FRAC_BITS +: COORD_W] : '0;
          state_nxt    = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= (state_r == BK_READ);
      prod_vld_r  <= rd_vld_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_q) begin
      base_r <= q_addr;
      dx_r   <= q_dx;
      dy_r   <= q_dy;
    end
    wt_r      <= wt_nxt;
    prod_u_r  <= ACC_W'(ram_rdata[COORD_W +: COORD_W]) * ACC_W'(wt_r);
    prod_v_r  <= ACC_W'(ram_rdata[0 +: COORD_W]) * ACC_W'(wt_r);
    prod_ok_r <= ram_rdata[WORD_W-1];
    if (start_q) begin
      acc_u_r <= '0;
      acc_v_r <= '0;
      allv_r  <= 1'b1;
    end else if (prod_vld_r) begin
      acc_u_r <= acc_u_r + prod_u_r;
      acc_v_r <= acc_v_r + prod_v_r;
      allv_r  <= allv_r & prod_ok_r;
    end
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_ok_r   <= out_ok_nxt;
      out_u_r    <= out_u_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(OUT_DATA_W - WORD_W)'(0), out_v_r, out_u_r, out_ok_r};

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ || state_r == BK_TAIL1 || state_r == BK_TAIL2) |-> !ram_we)
    else $error("map written during a neighbourhood read");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_u_r == '0 && out_v_r == '0))
    else $error("failed reply carries coordinates");
`endif

endmodule

// ===== design/projector_coordinate_map_sampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projector_coordinate_map_sampler_unit
// Camera-to-projector coordinate map: stores scaled phase pairs per pixel and
// answers subpixel queries by masked bilinear interpolation.
// ----------------------------------------------------------------------------
// After reset the map RAM is swept clear, one entry a cycle, over all IMG_W*IMG_H
// entries (262144 at the defaults); in_tready stays low until the sweep ends,
// configuration writes are taken throughout. Every request passes a two-stage
// front end (capture, then phase scaling and bound checks) and a four-entry
// queue. In the back end a store or an out-of-image query is done in the
// state that takes it from the queue; an in-image query passes that state,
// four reads of the single read port of the map RAM, the tail states
// BK_TAIL1 and BK_TAIL2 and the reply load. Replies sit in an output
// register; the next request leaves the queue only once that register is free
// or empties in the same cycle, while a query's reads and tail run on.
module projector_coordinate_map_sampler_unit
  import pcms_pkg::*;
#(
  parameter int IMG_W     = 512,
  parameter int IMG_H     = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // opcode
  // pixel_x, pixel_y, phase_u, phase_v, phase_valid, point_x, point_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tuser,  // reply_kind
  output logic [OUT_DATA_W-1:0] out_tdata   // ok, proj_u, proj_v
);

  localparam int ADDR_W = $clog2(IMG_W * IMG_H);
  localparam int QW     = $bits(cmd_ctl_t) + $bits(coord_pair_t) + ADDR_W + 2 * FRAC_BITS;

  logic                 clr_done;
  logic                 q_full, q_empty, q_push, q_pop;
  logic [QW-1:0]        q_din, q_dout;
  cmd_ctl_t             f_ctl, b_ctl;
  coord_pair_t          f_coord, b_coord;
  logic [ADDR_W-1:0]    f_addr, b_addr;
  logic [FRAC_BITS-1:0] f_dx, f_dy, b_dx, b_dy;

  pcms_front #(
    .IMG_W     (IMG_W),
    .IMG_H     (IMG_H),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .clr_done  (clr_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (f_ctl),
    .q_coord   (f_coord),
    .q_addr    (f_addr),
    .q_dx      (f_dx),
    .q_dy      (f_dy)
  );

  assign q_din = {f_addr, f_dx, f_dy, f_coord, f_ctl};

  pcms_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_addr, b_dx, b_dy, b_coord, b_ctl} = q_dout;

  pcms_back #(
    .IMG_W     (IMG_W),
    .IMG_H     (IMG_H),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctl      (b_ctl),
    .q_coord    (b_coord),
    .q_addr     (b_addr),
    .q_dx       (b_dx),
    .q_dy       (b_dy),
    .q_pop      (q_pop),
    .clr_done   (clr_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
